/* rtl/rspt_pkg.sv */
// ----------------------------------------------------------------------------
// rspt_pkg: shared types and constants
// Item layout, back-end states, register indexes and status codes for the
// reset storm policy toggle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rspt_pkg;

  localparam int unsigned IN_DATA_W  = 136;
  localparam int unsigned OUT_DATA_W = 40;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic {
    OP_EVENT = 1'b0,
    OP_RANGE = 1'b1
  } op_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_OFF_COUNT = 3'd0,
    CFG_OFF_TIME  = 3'd1,
    CFG_ON_COUNT  = 3'd2,
    CFG_ON_TIME   = 3'd3,
    CFG_RANGE_CNT = 3'd4
  } cfg_idx_e;

  localparam logic [1:0] ST_ALREADY_ON  = 2'd0;
  localparam logic [1:0] ST_ALREADY_OFF = 2'd1;
  localparam logic [1:0] ST_TURNED_OFF  = 2'd2;
  localparam logic [1:0] ST_TURNED_ON   = 2'd3;

  typedef struct packed {
    op_e         op;
    logic [31:0] module_id;
    logic [31:0] event_time;
    logic [3:0]  range_index;
    logic [31:0] range_first;
    logic [31:0] range_last;
  } item_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_PREP,
    B_WALK,
    B_EVAL,
    B_RESULT
  } back_state_e;

endpackage

`default_nettype wire

/* rtl/rspt_front.sv */
// ----------------------------------------------------------------------------
// rspt_front: input stage
// Takes input transfers, unpacks them into items and holds them in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rspt_front (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_tvalid_i,
  output logic                                s_tready_o,
  input  wire logic [rspt_pkg::IN_DATA_W-1:0] s_tdata_i,
  input  wire logic                           s_tuser_i,
  output logic                                q_valid_o,
  input  wire logic                           q_ready_i,
  output rspt_pkg::item_t                     q_item_o
);
  import rspt_pkg::*;

  item_t      mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;
  item_t      in_item;

  always_comb begin
    in_item.op          = op_e'(s_tuser_i);
    in_item.module_id   = s_tdata_i[31:0];
    in_item.event_time  = s_tdata_i[63:32];
    in_item.range_index = s_tdata_i[67:64];
    in_item.range_first = s_tdata_i[99:68];
    in_item.range_last  = s_tdata_i[131:100];
  end

  assign s_tready_o = (cnt_q != 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = mem_q[rd_ptr_q];
  assign push       = s_tvalid_i && s_tready_o;
  assign pop        = q_valid_o && q_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

/* rtl/rspt_back.sv */
// ----------------------------------------------------------------------------
// rspt_back: execution engine
// Holds ranges, registers and the event ring, walks the ring one record a
// cycle and registers the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rspt_back #(
  parameter int unsigned RECORD_DEPTH = 128,
  parameter int unsigned MAX_RANGES   = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [rspt_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [rspt_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                            q_valid_i,
  output logic                                 q_ready_o,
  input  wire rspt_pkg::item_t                 q_item_i,
  output logic                                 m_tvalid_o,
  input  wire logic                            m_tready_i,
  output logic [rspt_pkg::OUT_DATA_W-1:0]      m_tdata_o
);
  import rspt_pkg::*;

  localparam int unsigned AW = (RECORD_DEPTH > 1) ? $clog2(RECORD_DEPTH) : 1;
  localparam int unsigned CW = $clog2(RECORD_DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(RECORD_DEPTH - 1);

  // configuration
  logic [7:0]  off_cnt_thr_q, on_cnt_thr_q;
  logic [31:0] off_time_thr_q, on_time_thr_q;
  logic [4:0]  range_cnt_q;

  // ranges
  logic [31:0] range_lo_q [MAX_RANGES];
  logic [31:0] range_hi_q [MAX_RANGES];

  // event ring
  logic [31:0] ring_id  [RECORD_DEPTH];
  logic [31:0] ring_tm  [RECORD_DEPTH];
  logic [31:0] rd_id_q, rd_tm_q;

  back_state_e state_q, state_d;
  logic [31:0] seq_q, seq_d, since_q, since_d;
  logic        pol_q, pol_d;
  logic [AW-1:0] wp_q, wp_d, ptr_q, ptr_d;
  logic [CW-1:0] rem_q, rem_d;
  logic          pend_q, pend_d;
  logic [7:0]    need_q, need_d;
  logic          have_q, have_d;
  logic [31:0]   newest_q, newest_d, oldest_q, oldest_d;
  logic          ring_we, rd_en, range_we;
  logic          hit;
  logic [31:0]   avail32, gap32, span;
  logic [1:0]    status;
  logic          out_valid_q, out_load;
  logic [OUT_DATA_W-1:0] out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_cnt_thr_q  <= '0;
      off_time_thr_q <= '0;
      on_cnt_thr_q   <= '0;
      on_time_thr_q  <= '0;
      range_cnt_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_OFF_COUNT: off_cnt_thr_q  <= cfg_wdata_i[7:0];
        CFG_OFF_TIME:  off_time_thr_q <= cfg_wdata_i;
        CFG_ON_COUNT:  on_cnt_thr_q   <= cfg_wdata_i[7:0];
        CFG_ON_TIME:   on_time_thr_q  <= cfg_wdata_i;
        CFG_RANGE_CNT: range_cnt_q    <= cfg_wdata_i[4:0];
        default: ;
      endcase
    end
  end

  assign range_we = (state_q == B_IDLE) && q_valid_i && (q_item_i.op == OP_RANGE)
                    && (32'(q_item_i.range_index) < MAX_RANGES);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_RANGES; k++) begin
        range_lo_q[k] <= '0;
        range_hi_q[k] <= '0;
      end
    end else if (range_we) begin
      for (int k = 0; k < MAX_RANGES; k++) begin
        if (32'(q_item_i.range_index) == k) begin
          range_lo_q[k] <= q_item_i.range_first;
          range_hi_q[k] <= q_item_i.range_last;
        end
      end
    end
  end

  // match of the record read last cycle against the active ranges
  always_comb begin
    hit = 1'b0;
    for (int k = 0; k < MAX_RANGES; k++) begin
      if ((k < 32'(range_cnt_q)) && (rd_id_q >= range_lo_q[k]) && (rd_id_q <= range_hi_q[k]))
        hit = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_id[wp_q] <= q_item_i.module_id;
      ring_tm[wp_q] <= q_item_i.event_time;
    end
    if (rd_en) begin
      rd_id_q <= ring_id[ptr_q];
      rd_tm_q <= ring_tm[ptr_q];
    end
  end

  assign gap32   = seq_q - since_q;
  assign span    = newest_q - oldest_q;

  always_comb begin
    state_d  = state_q;
    seq_d    = seq_q;
    since_d  = since_q;
    pol_d    = pol_q;
    wp_d     = wp_q;
    ptr_d    = ptr_q;
    rem_d    = rem_q;
    pend_d   = 1'b0;
    need_d   = need_q;
    have_d   = have_q;
    newest_d = newest_q;
    oldest_d = oldest_q;
    ring_we  = 1'b0;
    rd_en    = 1'b0;
    q_ready_o = 1'b0;
    out_load  = 1'b0;
    avail32   = (seq_q >= RECORD_DEPTH) ? 32'(RECORD_DEPTH) : seq_q;
    if (gap32 < avail32) avail32 = gap32;
    case (state_q)
      B_IDLE: begin
        q_ready_o = 1'b1;
        if (q_valid_i) begin
          if (q_item_i.op == OP_RANGE) begin
            state_d = B_RESULT;
          end else begin
            ring_we = 1'b1;
            seq_d   = seq_q + 32'd1;
            wp_d    = (seq_q == 32'hFFFF_FFFF || wp_q == LAST_SLOT) ? '0 : wp_q + 1'b1;
            state_d = B_PREP;
          end
        end
      end
      B_PREP: begin
        need_d = pol_q ? on_cnt_thr_q : off_cnt_thr_q;
        have_d = 1'b0;
        rem_d  = CW'(avail32);
        ptr_d  = (wp_q == '0) ? LAST_SLOT : wp_q - 1'b1;
        if (since_q > seq_q) begin
          since_d = '0;
          pol_d   = 1'b0;
          state_d = B_RESULT;
        end else if (need_d == 8'd0 || avail32 == 32'd0) begin
          state_d = B_RESULT;
        end else begin
          state_d = B_WALK;
        end
      end
      B_WALK: begin
        if (rem_q != '0) begin
          rd_en  = 1'b1;
          pend_d = 1'b1;
          rem_d  = rem_q - 1'b1;
          ptr_d  = (ptr_q == '0) ? LAST_SLOT : ptr_q - 1'b1;
        end
        if (pend_q && hit) begin
          need_d = need_q - 8'd1;
          if (!have_q) begin
            newest_d = rd_tm_q;
            have_d   = 1'b1;
          end
          if (need_q == 8'd1) begin
            oldest_d = rd_tm_q;
            pend_d   = 1'b0;
            state_d  = B_EVAL;
          end
        end else if (!pend_q && rem_q == '0) begin
          state_d = B_RESULT;
        end
      end
      B_EVAL: begin
        if (span != 32'd0 && span <= (pol_q ? on_time_thr_q : off_time_thr_q)) begin
          pol_d   = ~pol_q;
          since_d = seq_q;
        end
        state_d = B_RESULT;
      end
      B_RESULT: begin
        if (!out_valid_q) begin
          out_load = 1'b1;
          state_d  = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    if (seq_q == 32'd0)  status = ST_ALREADY_ON;
    else if (pol_q)      status = (since_q != seq_q) ? ST_ALREADY_OFF : ST_TURNED_OFF;
    else                 status = (since_q != seq_q) ? ST_ALREADY_ON : ST_TURNED_ON;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      seq_q       <= '0;
      since_q     <= '0;
      pol_q       <= 1'b0;
      wp_q        <= '0;
      ptr_q       <= '0;
      rem_q       <= '0;
      pend_q      <= 1'b0;
      need_q      <= '0;
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      seq_q   <= seq_d;
      since_q <= since_d;
      pol_q   <= pol_d;
      wp_q    <= wp_d;
      ptr_q   <= ptr_d;
      rem_q   <= rem_d;
      pend_q  <= pend_d;
      need_q  <= need_d;
      have_q  <= have_d;
      if (out_load)        out_valid_q <= 1'b1;
      else if (m_tready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    newest_d_reg: begin
      newest_q <= newest_d;
      oldest_q <= oldest_d;
    end
    if (out_load) out_q <= {5'd0, seq_q, status, pol_q};
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_q;

`ifndef ASSERT_OFF
  a_walk_need: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_WALK) |-> (need_q != 8'd0))
    else $error("walk running with no matches left to find");
  a_result_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_RESULT && !out_valid_q) |=> (state_q == B_IDLE && out_valid_q))
    else $error("result not registered");
  a_wp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(wp_q) < RECORD_DEPTH))
    else $error("ring write slot out of range");
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(rem_q) <= RECORD_DEPTH))
    else $error("walk length beyond ring depth");
`endif

endmodule

`default_nettype wire

/* rtl/reset_storm_policy_toggle.sv */
// ----------------------------------------------------------------------------
// reset_storm_policy_toggle: reset storm policy engine
// Records reset events in a ring and toggles an on/off policy when enough
// events from the watched module ranges arrive within a time window.
// ----------------------------------------------------------------------------
//
//  channel   dir  signals                       content
//  s_axis    in   tvalid/tready/tdata/tuser     one event or range write
//  m_axis    out  tvalid/tready/tdata           policy, status, event count
//  cfg       in   cfg_we/cfg_addr/cfg_wdata     threshold and range count regs
//
//  range write: idle state, then the result state loads the result register
//  event: prep, walk, eval and result; the walk reads up to avail records
//    (up to RECORD_DEPTH) through the one-record-per-cycle ring read port;
//    it stops early at the threshold-th match, and prep skips it when not needed
//  a two-entry queue takes new transfers while the engine is busy
//  the result register holds one result; the engine waits while it is full
//  reset clears registers, policy and ranges; the ring needs no clearing
`timescale 1ns / 1ps
`default_nettype none

module reset_storm_policy_toggle #(
  parameter int unsigned RECORD_DEPTH = 128,
  parameter int unsigned MAX_RANGES   = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [rspt_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [rspt_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                            s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // module_id, event_time, range_index, range_first, range_last, zero pad
  input  wire logic [rspt_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // op
  input  wire logic                            s_axis_tuser_i,
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  // policy_off, transition_status, event_count, zero pad
  output logic [rspt_pkg::OUT_DATA_W-1:0]      m_axis_tdata_o
);
  import rspt_pkg::*;

  // queue between front and engine
  logic  q_valid, q_ready;
  item_t q_item;

  rspt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .s_tdata_i  (s_axis_tdata_i),
    .s_tuser_i  (s_axis_tuser_i),
    .q_valid_o  (q_valid),
    .q_ready_i  (q_ready),
    .q_item_o   (q_item)
  );

  rspt_back #(
    .RECORD_DEPTH (RECORD_DEPTH),
    .MAX_RANGES   (MAX_RANGES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_item_i    (q_item),
    .m_tvalid_o  (m_axis_tvalid_o),
    .m_tready_i  (m_axis_tready_i),
    .m_tdata_o   (m_axis_tdata_o)
  );

endmodule

`default_nettype wire

/* tb/sv/reset_storm_policy_toggle_tb.sv */
// ----------------------------------------------------------------------------
// reset_storm_policy_toggle_tb: self-checking bench for the policy engine
// Drives event and range-write transfers from a queue, predicts the policy,
// transition status and event count of every transfer with an in-bench
// model of the ring walk, and checks each output transfer in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module reset_storm_policy_toggle_tb;
  import rspt_pkg::*;

  localparam int unsigned DEPTH  = 128;
  localparam int unsigned NRANGE = 16;

  typedef struct {
    logic        policy_off;
    logic [1:0]  status;
    logic [31:0] count;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  // module_id, event_time, range_index, range_first, range_last, zero pad
  logic [IN_DATA_W-1:0] s_axis_tdata_i = '0;
  // op
  logic s_axis_tuser_i = 1'b0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  // policy_off, transition_status, event_count, zero pad
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;

  reset_storm_policy_toggle dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_wdata_i,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i, .s_axis_tuser_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // mirror of the block state used for prediction
  logic [7:0]  thr_off_cnt, thr_on_cnt;
  logic [31:0] thr_off_span, thr_on_span;
  logic [4:0]  ranges_used;
  logic [31:0] ring_ids [DEPTH];
  logic [31:0] ring_times [DEPTH];
  logic [31:0] seq_cnt;
  logic        pol_off;
  logic [31:0] pol_since;
  logic [31:0] rng_lo [NRANGE];
  logic [31:0] rng_hi [NRANGE];

  item_t    pending_items[$];
  verdict_t expected_verdicts[$];
  item_t    cur_item;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic hold_go = 1'b0;
  int   hold_left = 0;
  int   fail_cnt = 0;

  function automatic logic id_watched(logic [31:0] id);
    int n;
    n = (ranges_used > NRANGE) ? NRANGE : ranges_used;
    for (int k = 0; k < n; k++)
      if (id >= rng_lo[k] && id <= rng_hi[k]) return 1'b1;
    return 1'b0;
  endfunction

  // ring walk back from the newest event since the last policy change
  function automatic void walk_policy();
    logic [31:0] avail, need, span_lim, newest, oldest, span;
    logic have_newest;
    int slot;
    avail = (seq_cnt >= DEPTH) ? DEPTH : seq_cnt;
    need = pol_off ? thr_on_cnt : thr_off_cnt;
    span_lim = pol_off ? thr_on_span : thr_off_span;
    newest = '0;
    oldest = '0;
    have_newest = 1'b0;
    // change point ahead of the count, only after a wrap
    if (pol_since > seq_cnt) begin
      pol_since = '0;
      pol_off = 1'b0;
      return;
    end
    if (seq_cnt - pol_since < avail) avail = seq_cnt - pol_since;
    for (int k = 0; k < avail && need != 0; k++) begin
      slot = (seq_cnt - k - 1) % DEPTH;
      if (!id_watched(ring_ids[slot])) continue;
      need--;
      if (!have_newest) begin
        newest = ring_times[slot];
        have_newest = 1'b1;
      end
      if (need == 0) begin
        oldest = ring_times[slot];
        break;
      end
    end
    span = newest - oldest;
    if (need == 0 && span != 0 && span <= span_lim) begin
      pol_off = ~pol_off;
      pol_since = seq_cnt;
    end
  endfunction

  function automatic verdict_t apply_item(item_t it);
    verdict_t v;
    int slot;
    if (it.op == OP_RANGE) begin
      rng_lo[it.range_index] = it.range_first;
      rng_hi[it.range_index] = it.range_last;
    end else begin
      slot = seq_cnt % DEPTH;
      ring_ids[slot] = it.module_id;
      ring_times[slot] = it.event_time;
      seq_cnt = seq_cnt + 1;
      walk_policy();
    end
    v.policy_off = pol_off;
    v.count = seq_cnt;
    if (seq_cnt == 0) v.status = ST_ALREADY_ON;
    else if (pol_off) v.status = (pol_since != seq_cnt) ? ST_ALREADY_OFF : ST_TURNED_OFF;
    else v.status = (pol_since != seq_cnt) ? ST_ALREADY_ON : ST_TURNED_ON;
    return v;
  endfunction

  function automatic logic [IN_DATA_W-1:0] pack_item(item_t it);
    logic [IN_DATA_W-1:0] d;
    d = '0;
    d[31:0]    = it.module_id;
    d[63:32]   = it.event_time;
    d[67:64]   = it.range_index;
    d[99:68]   = it.range_first;
    d[131:100] = it.range_last;
    return d;
  endfunction

  // driver: predicts on every accepted transfer, then offers the next item
  always @(posedge clk_i or negedge rst_ni) begin
    logic nxt_valid;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      nxt_valid = s_axis_tvalid_i;
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        expected_verdicts.push_back(apply_item(cur_item));
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && pending_items.size() != 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        cur_item = pending_items.pop_front();
        s_axis_tdata_i <= pack_item(cur_item);
        s_axis_tuser_i <= cur_item.op;
        nxt_valid = 1'b1;
      end
      s_axis_tvalid_i <= nxt_valid;
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk_i) begin
    if (hold_go) hold_left <= 600;
    else if (hold_left > 0) hold_left <= hold_left - 1;
  end

  // monitor: compares each output transfer with the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t e;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (expected_verdicts.size() == 0) begin
          $error("unexpected output transfer %h", m_axis_tdata_o);
          fail_cnt++;
        end else begin
          e = expected_verdicts.pop_front();
          if (m_axis_tdata_o[0] !== e.policy_off) begin
            $error("policy_off: expected %0d, got %0d", e.policy_off, m_axis_tdata_o[0]);
            fail_cnt++;
          end
          if (m_axis_tdata_o[2:1] !== e.status) begin
            $error("transition_status: expected %0d, got %0d", e.status,
                   m_axis_tdata_o[2:1]);
            fail_cnt++;
          end
          if (m_axis_tdata_o[34:3] !== e.count) begin
            $error("event_count: expected %0d, got %0d", e.count, m_axis_tdata_o[34:3]);
            fail_cnt++;
          end
        end
      end
      m_axis_tready_i <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_OFF_COUNT: thr_off_cnt = val[7:0];
      CFG_OFF_TIME:  thr_off_span = val;
      CFG_ON_COUNT:  thr_on_cnt = val[7:0];
      CFG_ON_TIME:   thr_on_span = val;
      CFG_RANGE_CNT: ranges_used = val[4:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic void queue_event(logic [31:0] id, logic [31:0] t);
    item_t it;
    it = '0;
    it.op = OP_EVENT;
    it.module_id = id;
    it.event_time = t;
    pending_items.push_back(it);
  endfunction

  function automatic void queue_range(logic [3:0] idx, logic [31:0] lo, logic [31:0] hi);
    item_t it;
    it = '0;
    it.op = OP_RANGE;
    it.range_index = idx;
    it.range_first = lo;
    it.range_last = hi;
    pending_items.push_back(it);
  endfunction

  // sender pause until every queued item has come back
  task automatic drain();
    while (pending_items.size() != 0 || s_axis_tvalid_i || expected_verdicts.size() != 0)
      @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_count(int ph);
    if (ph == 0) return 8'd0;
    if (ph == 1) return 8'd128;
    if (ph == 2) return 8'd255;
    case ($urandom_range(5))
      0: return 8'd1;
      1: return 8'd2;
      default: return 8'($urandom_range(2, 6));
    endcase
  endfunction

  function automatic logic [31:0] pick_span(int ph);
    if (ph == 3) return 32'd0;
    if (ph == 4) return 32'hFFFF_FFFF;
    return $urandom_range(1, 40);
  endfunction

  initial begin
    logic [31:0] tnow;
    logic [31:0] id;
    thr_off_cnt = '0; thr_on_cnt = '0; thr_off_span = '0; thr_on_span = '0;
    ranges_used = '0; seq_cnt = '0; pol_off = 1'b0; pol_since = '0;
    for (int i = 0; i < NRANGE; i++) begin
      rng_lo[i] = '0;
      rng_hi[i] = '0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset registers, then a short on-off-on storm
    queue_event(32'h0, 32'h0);
    queue_range(4'd15, 32'hFFFF_FFFF, 32'h0);
    drain();
    write_reg(CFG_OFF_COUNT, 32'd2);
    write_reg(CFG_OFF_TIME, 32'd10);
    write_reg(CFG_ON_COUNT, 32'd2);
    write_reg(CFG_ON_TIME, 32'd10);
    write_reg(CFG_RANGE_CNT, 32'd3);
    queue_range(4'd0, 32'd100, 32'd200);
    queue_range(4'd1, 32'hFFFF_0000, 32'hFFFF_FFFF);
    queue_range(4'd2, 32'd500, 32'd400);            // empty range
    queue_event(32'd100, 32'd1000);
    queue_event(32'd300, 32'd1003);                 // not watched
    queue_event(32'd200, 32'd1005);                 // span 5, turns off
    queue_event(32'hFFFF_FFFF, 32'd2000);
    queue_event(32'hFFFF_FFFF, 32'd2000);           // zero span
    queue_event(32'd150, 32'd2011);                 // span 11, too wide
    queue_event(32'd450, 32'd2012);
    queue_event(32'd160, 32'd2015);                 // span 4, turns on
    queue_event(32'd150, 32'd0);                    // newest match at time zero
    queue_event(32'd150, 32'hFFFF_FFFF);            // wrapped span
    queue_event(32'd199, 32'hFFFF_FFF8);
    drain();
    write_reg(CFG_RANGE_CNT, 32'd31);               // clamps to all ranges
    queue_event(32'd0, 32'd5);
    queue_event(32'd0, 32'd7);
    drain();

    // random phases, each with its own settings
    tnow = 32'd5000;
    for (int ph = 0; ph < 8; ph++) begin
      send_idle_pct = (ph < 3) ? 22 : (ph < 6) ? 49 : 0;
      recv_idle_pct = (ph < 3) ? 49 : (ph < 6) ? 22 : 0;
      write_reg(CFG_OFF_COUNT, pick_count(ph));
      write_reg(CFG_ON_COUNT, pick_count(ph == 0 ? 0 : ph + 5));
      write_reg(CFG_OFF_TIME, pick_span(ph));
      write_reg(CFG_ON_TIME, pick_span(ph == 3 ? 4 : ph));
      write_reg(CFG_RANGE_CNT, (ph == 5) ? 32'd16 : (ph == 6) ? 32'd0 : $urandom_range(1, 8));
      for (int r = 0; r < 4; r++)
        queue_range(r[3:0], 32'h1000 + r * 64, 32'h1000 + r * 64 + $urandom_range(63));
      for (int n = 0; n < 200; n++) begin
        if ($urandom_range(99) < 8) begin
          if ($urandom_range(1))
            queue_range(4'($urandom_range(15)), $urandom, $urandom);
          else
            queue_range(4'($urandom_range(15)), 32'h1000 + $urandom_range(255),
                        32'h1000 + $urandom_range(255));
        end else begin
          id = ($urandom_range(99) < 75) ? 32'h1000 + $urandom_range(255) : $urandom;
          case ($urandom_range(19))
            0: tnow = $urandom;
            1: tnow = tnow + $urandom_range(100, 1000);
            default: tnow = tnow + $urandom_range(0, 6);
          endcase
          queue_event(id, tnow);
        end
        if (ph == 1 && n == 20) begin
          // let the engine fill up behind a stalled receiver
          @(posedge clk_i);
          hold_go <= 1'b1;
          @(posedge clk_i);
          hold_go <= 1'b0;
        end
      end
      drain();
    end

    if (fail_cnt == 0 && expected_verdicts.size() == 0)
      $display("** reset_storm_policy_toggle: PASSED **");
    else
      $display("** reset_storm_policy_toggle: FAILED **");
    $finish;
  end

  initial begin
    #60_000_000;
    $display("** reset_storm_policy_toggle: FAILED **");
    $finish;
  end

endmodule
